// ===== design/tlcb_pkg.sv =====
// Shared types and codes for the thick line circle brush rasterizer.
// No dependencies; imported by tlcb_walk and thick_line_circle_brush_raster.
package tlcb_pkg;

  // Input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_BRUSH_RADIUS = 2'd0;
  localparam logic [1:0] REG_PEN_COLOR    = 2'd1;

  // Commands from the request side to the line/circle walker
  typedef struct packed {
    logic load;  // latch a new line
    logic step;  // advance to the next (x, yi) pair
  } walk_cmd_t;

  // Current brush position and circle pair
  typedef struct packed {
    logic signed [12:0] cx;  // line point column
    logic signed [12:0] cy;  // line point row
    logic signed [7:0]  a;   // circle x
    logic signed [7:0]  b;   // inner run y
  } walk_pt_t;

endpackage

// ===== design/tlcb_walk.sv =====
// Bresenham line walker with Bresenham filled-circle stepping.
// Depends on tlcb_pkg (walk_cmd_t, walk_pt_t).
module tlcb_walk
  import tlcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  walk_cmd_t          cmd,
  input  logic signed [11:0] start_x,
  input  logic signed [11:0] start_y,
  input  logic signed [11:0] end_x,
  input  logic signed [11:0] end_y,
  input  logic [6:0]         radius,
  output logic               busy,
  output walk_pt_t           pt,
  output logic               fin
);

  logic signed [12:0] line_x_r, line_x_nxt, line_y_r, line_y_nxt;
  logic signed [12:0] target_x_r, target_x_nxt, target_y_r, target_y_nxt;
  logic [11:0]        span_x_r, span_x_nxt, span_y_r, span_y_nxt;
  logic               step_x_neg_r, step_x_neg_nxt, step_y_neg_r, step_y_neg_nxt;
  logic signed [12:0] line_error_r, line_error_nxt;
  logic signed [7:0]  circle_x_r, circle_x_nxt, circle_y_r, circle_y_nxt;
  logic signed [7:0]  inner_y_r, inner_y_nxt;
  logic signed [11:0] circle_decision_r, circle_decision_nxt;
  logic               busy_r, busy_nxt;

  logic signed [12:0] x0, y0, x1, y1, dx, dy;
  logic [11:0]        sx_abs, sy_abs;
  logic signed [7:0]  cx_inc, cy_dec, r_ext;
  logic signed [11:0] dec_upd, dec_init;
  logic signed [13:0] err_w, spx_w, spy_w, err_upd;
  logic               go_x, go_y;
  logic signed [12:0] lx_step, ly_step;

  assign busy = busy_r;
  assign pt   = '{cx: line_x_r, cy: line_y_r, a: circle_x_r, b: inner_y_r};

  always_comb begin
    // Load arithmetic
    x0 = 13'(start_x);
    y0 = 13'(start_y);
    x1 = 13'(end_x);
    y1 = 13'(end_y);
    dx = x1 - x0;
    dy = y1 - y0;
    sx_abs = dx[12] ? 12'(-dx) : dx[11:0];
    sy_abs = dy[12] ? 12'(-dy) : dy[11:0];
    r_ext    = $signed({1'b0, radius});
    dec_init = 12'sd3 - $signed({4'b0, radius, 1'b0});

    // Circle stepping
    if (circle_decision_r[11]) begin
      dec_upd = circle_decision_r + (12'(circle_x_r) <<< 2) + 12'sd6;
      cy_dec  = circle_y_r;
    end else begin
      dec_upd = circle_decision_r + (12'(circle_x_r - circle_y_r) <<< 2) + 12'sd10;
      cy_dec  = circle_y_r - 8'sd1;
    end
    cx_inc = circle_x_r + 8'sd1;

    // Line stepping
    err_w = 14'(line_error_r);
    spx_w = $signed({2'b00, span_x_r});
    spy_w = $signed({2'b00, span_y_r});
    go_x  = err_w > -spx_w;
    go_y  = err_w < spy_w;
    err_upd = err_w - (go_x ? spy_w : 14'sd0) + (go_y ? spx_w : 14'sd0);
    lx_step = go_x ? (step_x_neg_r ? line_x_r - 13'sd1 : line_x_r + 13'sd1) : line_x_r;
    ly_step = go_y ? (step_y_neg_r ? line_y_r - 13'sd1 : line_y_r + 13'sd1) : line_y_r;

    // Hold by default
    line_x_nxt = line_x_r;
    line_y_nxt = line_y_r;
    target_x_nxt = target_x_r;
    target_y_nxt = target_y_r;
    span_x_nxt = span_x_r;
    span_y_nxt = span_y_r;
    step_x_neg_nxt = step_x_neg_r;
    step_y_neg_nxt = step_y_neg_r;
    line_error_nxt = line_error_r;
    circle_x_nxt = circle_x_r;
    circle_y_nxt = circle_y_r;
    inner_y_nxt = inner_y_r;
    circle_decision_nxt = circle_decision_r;
    busy_nxt = busy_r;
    fin = 1'b0;

    if (cmd.load) begin
      span_x_nxt = sx_abs;
      span_y_nxt = sy_abs;
      step_x_neg_nxt = !(x0 < x1);
      step_y_neg_nxt = !(y0 < y1);
      line_error_nxt = (sx_abs > sy_abs) ? $signed({2'b00, sx_abs[11:1]})
                                         : -$signed({2'b00, sy_abs[11:1]});
      line_x_nxt = x0;
      line_y_nxt = y0;
      target_x_nxt = x1;
      target_y_nxt = y1;
      busy_nxt = !(x0 == x1 && y0 == y1);
      circle_x_nxt = 8'sd0;
      circle_y_nxt = r_ext;
      inner_y_nxt = 8'sd0;
      circle_decision_nxt = dec_init;
    end else if (cmd.step && busy_r) begin
      if (inner_y_r < circle_y_r) begin
        // Inner run continues
        inner_y_nxt = inner_y_r + 8'sd1;
      end else if (cx_inc <= cy_dec) begin
        // Next octant pair
        circle_decision_nxt = dec_upd;
        circle_y_nxt = cy_dec;
        circle_x_nxt = cx_inc;
        inner_y_nxt = cx_inc;
      end else begin
        // Circle done: move along the line
        line_error_nxt = err_upd[12:0];
        line_x_nxt = lx_step;
        line_y_nxt = ly_step;
        if (lx_step == target_x_r && ly_step == target_y_r) begin
          busy_nxt = 1'b0;
          fin = 1'b1;
          circle_decision_nxt = dec_upd;
          circle_y_nxt = cy_dec;
          circle_x_nxt = cx_inc;
        end else begin
          circle_x_nxt = 8'sd0;
          circle_y_nxt = r_ext;
          inner_y_nxt = 8'sd0;
          circle_decision_nxt = dec_init;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_x_r <= '0;
      line_y_r <= '0;
      target_x_r <= '0;
      target_y_r <= '0;
      span_x_r <= '0;
      span_y_r <= '0;
      step_x_neg_r <= 1'b0;
      step_y_neg_r <= 1'b0;
      line_error_r <= '0;
      circle_x_r <= '0;
      circle_y_r <= '0;
      inner_y_r <= '0;
      circle_decision_r <= '0;
      busy_r <= 1'b0;
    end else begin
      line_x_r <= line_x_nxt;
      line_y_r <= line_y_nxt;
      target_x_r <= target_x_nxt;
      target_y_r <= target_y_nxt;
      span_x_r <= span_x_nxt;
      span_y_r <= span_y_nxt;
      step_x_neg_r <= step_x_neg_nxt;
      step_y_neg_r <= step_y_neg_nxt;
      line_error_r <= line_error_nxt;
      circle_x_r <= circle_x_nxt;
      circle_y_r <= circle_y_nxt;
      inner_y_r <= inner_y_nxt;
      circle_decision_r <= circle_decision_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Finishing a line always drops busy
  assert property (@(posedge clk) disable iff (!rst_n) fin |=> !busy_r)
    else $error("walker finished a line but stayed busy");
  // Without a command the walker holds its position
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !cmd.load && !cmd.step) |=> $stable(inner_y_r) && $stable(line_x_r))
    else $error("walker state moved without a command");
  // A load always restarts the circle at x = 0
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (circle_x_r == 8'sd0) && (inner_y_r == 8'sd0))
    else $error("load did not restart the circle");

endmodule

// ===== design/thick_line_circle_brush_raster.sv =====
// Top level of the thick line rasterizer with a filled circular brush.
// Depends on tlcb_pkg and tlcb_walk.
//
// A load request (operation 0) latches a line and gives no result.
// A next request (operation 1) gives the eight symmetric pixel writes of one
// circle pair, one result per cycle from the result register while out_ready is
// high, or the single done result when no line is active. The walker advances
// when the request is taken, and the next request is accepted in the cycle the
// last result of the previous one leaves, so a steady stream of next requests
// keeps the result port busy every cycle while out_ready is high. Pixels outside
// SCREEN_W x SCREEN_H have visible low and zero coordinates; the eighth result of
// the request that finishes a line has done_res high.
module thick_line_circle_brush_raster
  import tlcb_pkg::*;
#(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 600
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration write port
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  // Request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic signed [11:0] in_start_x,
  input  logic signed [11:0] in_start_y,
  input  logic signed [11:0] in_end_x,
  input  logic signed [11:0] in_end_y,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_pixel_x,
  output logic [9:0]         out_pixel_y,
  output logic [31:0]        out_write_color,
  output logic               out_visible,
  output logic               out_done_res,
  output logic               out_last
);

  localparam logic signed [13:0] SCR_W = 14'(SCREEN_W);
  localparam logic signed [13:0] SCR_H = 14'(SCREEN_H);

  logic [6:0]  brush_radius_r;
  logic [31:0] pen_color_r;

  walk_cmd_t cmd;
  walk_pt_t  pt;
  logic      busy, fin;

  logic      grp_valid_r, grp_valid_nxt;
  logic      grp_idle_r, grp_idle_nxt;
  logic      grp_fin_r, grp_fin_nxt;
  walk_pt_t  grp_pt_r, grp_pt_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic in_fire, out_fire, item_last;
  logic signed [7:0]  u, v;
  logic signed [13:0] px, py;
  logic vis;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brush_radius_r <= '0;
      pen_color_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BRUSH_RADIUS: brush_radius_r <= cfg_wdata[6:0];
        REG_PEN_COLOR:    pen_color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake
  assign item_last = grp_idle_r || (idx_r == 3'd7);
  assign in_ready  = !grp_valid_r || (out_ready && item_last);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign cmd.load = in_fire && (in_operation == OP_LOAD);
  assign cmd.step = in_fire && (in_operation == OP_NEXT);

  tlcb_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .radius  (brush_radius_r),
    .busy    (busy),
    .pt      (pt),
    .fin     (fin)
  );

  // Result group register and drain index
  always_comb begin
    grp_valid_nxt = grp_valid_r;
    grp_idle_nxt  = grp_idle_r;
    grp_fin_nxt   = grp_fin_r;
    grp_pt_nxt    = grp_pt_r;
    idx_nxt       = idx_r;
    if (out_fire) begin
      idx_nxt = idx_r + 3'd1;
      if (item_last) grp_valid_nxt = 1'b0;
    end
    if (cmd.step) begin
      grp_valid_nxt = 1'b1;
      grp_idle_nxt  = !busy;
      grp_fin_nxt   = fin;
      grp_pt_nxt    = pt;
      idx_nxt       = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      grp_idle_r  <= 1'b0;
      grp_fin_r   <= 1'b0;
      idx_r       <= '0;
    end else begin
      grp_valid_r <= grp_valid_nxt;
      grp_idle_r  <= grp_idle_nxt;
      grp_fin_r   <= grp_fin_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_pt_r <= grp_pt_nxt;
  end

  // Symmetric point for the current index, then screen clip
  always_comb begin
    u  = idx_r[2] ? grp_pt_r.b : grp_pt_r.a;
    v  = idx_r[2] ? grp_pt_r.a : grp_pt_r.b;
    px = idx_r[0] ? 14'(grp_pt_r.cx) - 14'(u) : 14'(grp_pt_r.cx) + 14'(u);
    py = idx_r[1] ? 14'(grp_pt_r.cy) - 14'(v) : 14'(grp_pt_r.cy) + 14'(v);
    vis = !grp_idle_r && !px[13] && !py[13] && (px < SCR_W) && (py < SCR_H);
  end

  assign out_valid       = grp_valid_r;
  assign out_pixel_x     = vis ? px[9:0] : 10'd0;
  assign out_pixel_y     = vis ? py[9:0] : 10'd0;
  assign out_write_color = pen_color_r;
  assign out_visible     = vis;
  assign out_last        = item_last;
  assign out_done_res    = grp_idle_r || (grp_fin_r && idx_r == 3'd7);

  // A next request always produces a result in the following cycle
  assert property (@(posedge clk) disable iff (!rst_n) cmd.step |=> out_valid)
    else $error("next request produced no result");
  // Done only ever marks the final result of a request
  assert property (@(posedge clk) disable iff (!rst_n) out_done_res |-> out_last)
    else $error("done flagged on a non-final result");
  // A taken result that is not the last is followed by another
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last) |=> out_valid && (idx_r == $past(idx_r) + 3'd1))
    else $error("result group drained early");
  // With no pending results the request side is open
  assert property (@(posedge clk) disable iff (!rst_n) !grp_valid_r |-> in_ready)
    else $error("request stalled with empty result register");

endmodule

// ===== test/tlcb_checker.sv =====
// Checker for the thick line circle brush rasterizer: watches the config port and both
// channels, predicts the pixel writes of each request and compares them in order.
// Depends on tlcb_pkg for operation codes and register indexes.
module tlcb_checker
  import tlcb_pkg::*;
#(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 600
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_operation,
  input  logic signed [11:0] in_start_x,
  input  logic signed [11:0] in_start_y,
  input  logic signed [11:0] in_end_x,
  input  logic signed [11:0] in_end_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [9:0]         out_pixel_x,
  input  logic [9:0]         out_pixel_y,
  input  logic [31:0]        out_write_color,
  input  logic               out_visible,
  input  logic               out_done_res,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]  px;
    logic [9:0]  py;
    logic [31:0] color;
    logic        vis;
    logic        done;
    logic        last;
  } pixel_write_t;

  pixel_write_t pixel_writes_q[$];

  // Register copies
  logic [6:0]  brush_r;
  logic [31:0] pen;

  // Line walk and circle state; int so signed compares match the block's math
  int pos_x, pos_y, goal_x, goal_y;
  int run_x, run_y;
  bit x_back, y_back;
  int walk_err;
  int arc_x, arc_y, fill_y, arc_dec;
  bit drawing;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Fresh circle at the current line point, radius taken now
  task automatic start_circle();
    arc_x   = 0;
    arc_y   = int'(brush_r);
    fill_y  = 0;
    arc_dec = 3 - 2 * int'(brush_r);
  endtask

  // Queue one pixel write, clipped to the screen
  task automatic push_pixel(input int px, input int py, input bit done, input bit last);
    pixel_write_t w;
    w.vis   = (px >= 0) && (py >= 0) && (px < SCREEN_W) && (py < SCREEN_H);
    w.px    = w.vis ? px[9:0] : '0;
    w.py    = w.vis ? py[9:0] : '0;
    w.color = pen;
    w.done  = done;
    w.last  = last;
    pixel_writes_q.push_back(w);
  endtask

  task automatic predict_request(input logic op, input int x0, input int y0,
                                 input int x1, input int y1);
    int cx, cy, a, b, e2;
    bit fin;
    fin = 1'b0;
    if (op == OP_LOAD) begin
      // latch the line; a zero-length line leaves the block idle
      run_x    = (x1 > x0) ? x1 - x0 : x0 - x1;
      run_y    = (y1 > y0) ? y1 - y0 : y0 - y1;
      x_back   = !(x0 < x1);
      y_back   = !(y0 < y1);
      walk_err = ((run_x > run_y) ? run_x : -run_y) / 2;
      pos_x    = x0;
      pos_y    = y0;
      goal_x   = x1;
      goal_y   = y1;
      drawing  = !(x0 == x1 && y0 == y1);
      if (drawing) start_circle();
    end else if (!drawing) begin
      // next with no line: single done marker
      push_pixel(-1, -1, 1'b1, 1'b1);
    end else begin
      cx = pos_x;
      cy = pos_y;
      a  = arc_x;
      b  = fill_y;
      // step to the next (x, yi) pair, then the next circle or line point
      if (fill_y < arc_y) begin
        fill_y++;
      end else begin
        if (arc_dec < 0) begin
          arc_dec += 4 * arc_x + 6;
        end else begin
          arc_dec += 4 * (arc_x - arc_y) + 10;
          arc_y--;
        end
        arc_x++;
        if (arc_x <= arc_y) begin
          fill_y = arc_x;
        end else begin
          e2 = walk_err;
          if (e2 > -run_x) begin
            walk_err -= run_y;
            pos_x += x_back ? -1 : 1;
          end
          if (e2 < run_y) begin
            walk_err += run_x;
            pos_y += y_back ? -1 : 1;
          end
          if (pos_x == goal_x && pos_y == goal_y) begin
            drawing = 1'b0;
            fin     = 1'b1;
          end else begin
            start_circle();
          end
        end
      end
      // eight-way symmetry of the pair
      push_pixel(cx + a, cy + b, 1'b0, 1'b0);
      push_pixel(cx - a, cy + b, 1'b0, 1'b0);
      push_pixel(cx + a, cy - b, 1'b0, 1'b0);
      push_pixel(cx - a, cy - b, 1'b0, 1'b0);
      push_pixel(cx + b, cy + a, 1'b0, 1'b0);
      push_pixel(cx - b, cy + a, 1'b0, 1'b0);
      push_pixel(cx + b, cy - a, 1'b0, 1'b0);
      push_pixel(cx - b, cy - a, fin, 1'b1);
    end
  endtask

  // Sample at the clock edge; inputs are driven with nonblocking updates
  always @(posedge clk) begin
    pixel_write_t got, want;
    if (!rst_n) begin
      brush_r  = '0;
      pen      = '0;
      pos_x    = 0;  pos_y  = 0;  goal_x = 0;  goal_y = 0;
      run_x    = 0;  run_y  = 0;
      x_back   = 1'b0;
      y_back   = 1'b0;
      walk_err = 0;
      arc_x    = 0;  arc_y  = 0;  fill_y = 0;  arc_dec = 0;
      drawing  = 1'b0;
      pixel_writes_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BRUSH_RADIUS: brush_r = cfg_wdata[6:0];
          REG_PEN_COLOR:    pen     = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_request(in_operation, int'(in_start_x), int'(in_start_y),
                        int'(in_end_x), int'(in_end_y));
      if (out_valid && out_ready) begin
        got = '{out_pixel_x, out_pixel_y, out_write_color, out_visible,
                out_done_res, out_last};
        if (pixel_writes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d vis=%0b",
                                    got.px, got.py, got.vis));
        end else begin
          want = pixel_writes_q.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "got x=%0d y=%0d c=%h v=%0b d=%0b l=%0b, want x=%0d y=%0d c=%h v=%0b d=%0b l=%0b",
              got.px, got.py, got.color, got.vis, got.done, got.last,
              want.px, want.py, want.color, want.vis, want.done, want.last));
        end
      end
    end
    pending <= pixel_writes_q.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the rasterizer testbench: clock, reset, config writes, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on tlcb_pkg, tlcb_checker and thick_line_circle_brush_raster.
module tb;
  import tlcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_W      = 1024;
  localparam int SCREEN_H      = 600;
  localparam int RANDOM_ITEMS  = 260;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  // Indexes past the register map, written to show they are ignored
  localparam logic [1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [1:0] REG_UNMAPPED_B = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_operation = OP_LOAD;
  logic signed [11:0] in_start_x = '0;
  logic signed [11:0] in_start_y = '0;
  logic signed [11:0] in_end_x = '0;
  logic signed [11:0] in_end_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [9:0]         out_pixel_x;
  logic [9:0]         out_pixel_y;
  logic [31:0]        out_write_color;
  logic               out_visible;
  logic               out_done_res;
  logic               out_last;

  int fail_count;
  int pending;
  int requests_sent = 0;
  int brush = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit hold_taken = 1'b0;
  bit hold_trigger = 1'b0;
  bit no_idle = 1'b0;

  thick_line_circle_brush_raster #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_write_color(out_write_color), .out_visible(out_visible),
    .out_done_res(out_done_res), .out_last(out_last)
  );

  tlcb_checker #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_write_color(out_write_color), .out_visible(out_visible),
    .out_done_res(out_done_res), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_trigger && !hold_taken) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 17);
    end
  end

  // Watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // One request; holds valid and payload until taken
  task automatic send_request(input logic op, input int x0, input int y0,
                              input int x1, input int y1);
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < 17) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_start_x   <= x0[11:0];
    in_start_y   <= y0[11:0];
    in_end_x     <= x1[11:0];
    in_end_y     <= y1[11:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Next request; coordinate fields are unused, so they carry noise
  task automatic send_next();
    send_request(OP_NEXT, int'($urandom), int'($urandom), int'($urandom),
                 int'($urandom));
  endtask

  // Wait until every predicted write has come out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes on back-to-back edges; only call while drained
  task automatic program_regs(input int radius, input logic [31:0] color,
                              input bit with_unmapped);
    cfg_wr_en <= 1'b1;
    if (with_unmapped) begin
      cfg_index <= REG_UNMAPPED_A;
      cfg_wdata <= $urandom;
      @(posedge clk);
      cfg_index <= REG_UNMAPPED_B;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_index <= REG_BRUSH_RADIUS;
    cfg_wdata <= 32'(radius);
    @(posedge clk);
    cfg_index <= REG_PEN_COLOR;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    brush = radius;
  endtask

  // One line: load, then roughly enough next requests to finish it
  task automatic run_line();
    int x0, y0, dx, dy, steps, count, pairs;
    if ($urandom_range(9) == 0) begin
      // anywhere in the coordinate range; usually abandoned by the next load
      send_request(OP_LOAD, int'($urandom), int'($urandom), int'($urandom),
                   int'($urandom));
      count = $urandom_range(4);
    end else begin
      x0 = int'($urandom_range(1100)) - 40;
      y0 = int'($urandom_range(680)) - 40;
      dx = int'($urandom_range(12)) - 6;
      dy = int'($urandom_range(12)) - 6;
      send_request(OP_LOAD, x0, y0, x0 + dx, y0 + dy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      steps = (dx > dy) ? dx : dy;
      // (x, yi) pairs in one filled circle of small radius
      case (brush)
        0:       pairs = 1;
        1:       pairs = 2;
        2:       pairs = 5;
        3:       pairs = 8;
        4:       pairs = 12;
        default: pairs = 0;
      endcase
      count = (pairs == 0) ? 30 : steps * pairs;
      if ($urandom_range(5) == 0) count = $urandom_range(count);
      count += $urandom_range(2);
    end
    repeat (count) send_next();
  endtask

  initial begin
    int phase, phase_end, radius;
    logic [31:0] color;

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // next with no line, straight out of reset
    send_next();

    // unmapped indexes are ignored; full-scale color
    drain();
    program_regs(1, 32'hFFFF_FFFF, 1'b1);

    // zero-length line stays idle
    send_request(OP_LOAD, 100, 100, 100, 100);
    send_next();

    // one-step line at the origin, mostly off screen, then an idle next
    send_request(OP_LOAD, 0, 0, 1, 0);
    repeat (3) send_next();

    // extreme endpoints, abandoned by a second load
    send_request(OP_LOAD, -2048, -2048, 2047, 2047);
    repeat (2) send_next();
    send_request(OP_LOAD, 2047, 2047, -2048, -2048);
    repeat (2) send_next();

    // across the bottom-right screen corner
    send_request(OP_LOAD, SCREEN_W - 1, SCREEN_H - 1, SCREEN_W + 1, SCREEN_H + 1);
    repeat (4) send_next();

    // radius change while a line is in progress
    send_request(OP_LOAD, 500, 300, 502, 300);
    send_next();
    drain();
    program_regs(0, $urandom, 1'b0);
    repeat (3) send_next();

    // random phases, each with its own register setting
    phase = 0;
    while (requests_sent < RANDOM_ITEMS) begin
      drain();
      if (phase == 1)
        radius = 127;
      else if (phase == 7 || $urandom_range(9) == 0)
        radius = $urandom_range(5, 127);
      else
        radius = $urandom_range(4);
      case (phase % 4)
        0:       color = '0;
        1:       color = '1;
        default: color = $urandom;
      endcase
      program_regs(radius, color, 1'b0);
      no_idle <= (phase == 1);
      if (phase == 2) hold_trigger <= 1'b1;
      phase_end = requests_sent + $urandom_range(20, 40);
      while (requests_sent < phase_end) run_line();
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
